// ===== hw/rtl/tce_pkg.sv =====
// Shared types, constants and fold helper for the transport checksum engine.
package tce_pkg;

    // Pseudo-header modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_TCP  = 2'd1;
    localparam logic [1:0] MODE_UDP  = 2'd2;

    // IPv4 protocol numbers placed in the pseudo-header
    localparam logic [15:0] PROTO_TCP = 16'd6;
    localparam logic [15:0] PROTO_UDP = 16'd17;

    // Mask applied to the data word of an odd tail
    localparam logic [15:0] ODD_TAIL_MASK = 16'hFF00;

    // One accepted request, as captured by the input register
    typedef struct packed {
        logic        first;
        logic [1:0]  pseudo_mode;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] segment_length;
        logic [15:0] data_word;
        logic        odd_tail;
        logic        last;
    } tce_item_t;

    // Fold a sum of up to eight 16-bit terms into a ones'-complement 16-bit value.
    // The result is zero only when the sum itself is zero.
    function automatic logic [15:0] tce_fold(input logic [18:0] value);
        logic [16:0] partial;
        partial = {1'b0, value[15:0]} + {14'b0, value[18:16]};
        return partial[15:0] + {15'b0, partial[16]};
    endfunction

endpackage

// ===== hw/rtl/transport_checksum_engine.sv =====
// Top level: TCP/UDP/ICMP checksum engine, one 16-bit segment word per cycle.
// A final word is held in the input register, then its checksum is registered and shown on m_ports.
// Throughput: one request per cycle unless stalled; the running-sum adder and fold are combinational.
// A final word stalls only while the previous checksum is still waiting to be taken.
// Reset (aresetn low, synchronous) empties both register stages and clears the running sum.
module transport_checksum_engine
    import tce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first,
    input  logic [1:0]  s_pseudo_mode,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_dest_address,
    input  logic [15:0] s_segment_length,
    input  logic [15:0] s_data_word,
    input  logic        s_odd_tail,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum
);

    tce_item_t s_item;
    tce_item_t a_item;
    logic      a_valid;
    logic      a_advance;

    // Gather the request fields
    always_comb begin
        s_item.first          = s_first;
        s_item.pseudo_mode    = s_pseudo_mode;
        s_item.source_address = s_source_address;
        s_item.dest_address   = s_dest_address;
        s_item.segment_length = s_segment_length;
        s_item.data_word      = s_data_word;
        s_item.odd_tail       = s_odd_tail;
        s_item.last           = s_last;
    end

    tce_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .a_valid   (a_valid),
        .a_item    (a_item),
        .a_advance (a_advance)
    );

    tce_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .a_valid    (a_valid),
        .a_item     (a_item),
        .a_advance  (a_advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_checksum (m_checksum)
    );

`ifndef SYNTHESIS
    // A result appears only after a final word moved into the result slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(a_advance && a_item.last))
        else $error("result appeared without a final word");

    // A final word never overwrites a result still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_advance && a_item.last) |-> (!m_valid || m_ready))
        else $error("waiting result overwritten");

    // Backpressure only while the input stage holds a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> a_valid)
        else $error("input stalled while empty");

    // Non-final words always move on in the cycle after capture
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid && !a_item.last) |-> a_advance)
        else $error("non-final word stalled");
`endif

endmodule

// ===== hw/rtl/tce_in_reg.sv =====
// Input register stage: captures one request and holds it until the adder takes it.
module tce_in_reg
    import tce_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tce_item_t s_item,
    output logic      a_valid,
    output tce_item_t a_item,
    input  logic      a_advance
);

    logic      valid_reg;
    logic      valid_next;
    tce_item_t item_reg;

    // Take a new request when empty or when the held one moves on this cycle
    assign s_ready    = !valid_reg || a_advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign a_valid = valid_reg;
    assign a_item  = item_reg;

endmodule

// ===== hw/rtl/tce_accum.sv =====
// Ones'-complement accumulator with running sum and registered checksum output.
module tce_accum
    import tce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        a_valid,
    input  tce_item_t   a_item,
    output logic        a_advance,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [15:0] chk_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] proto;
    logic        use_pseudo;
    logic [18:0] pseudo_total;
    logic [15:0] pseudo_fold;
    logic [15:0] base;
    logic [15:0] word;
    logic [16:0] word_total;

    // Advance unless a final word would overwrite a result still waiting
    assign a_advance = a_valid && (!a_item.last || !out_valid_reg || m_ready);

    // Select the protocol number for the pseudo-header
    always_comb begin
        case (a_item.pseudo_mode) inside
            MODE_TCP: begin
                proto      = PROTO_TCP;
                use_pseudo = 1'b1;
            end
            MODE_UDP: begin
                proto      = PROTO_UDP;
                use_pseudo = 1'b1;
            end
            default: begin
                proto      = 16'h0000;
                use_pseudo = 1'b0;
            end
        endcase
    end

    // Sum the pseudo-header terms and fold
    assign pseudo_total = {3'b0, a_item.source_address[31:16]}
                        + {3'b0, a_item.source_address[15:0]}
                        + {3'b0, a_item.dest_address[31:16]}
                        + {3'b0, a_item.dest_address[15:0]}
                        + {3'b0, proto}
                        + {3'b0, a_item.segment_length};
    assign pseudo_fold  = tce_fold(pseudo_total);

    // Restart on the first word, otherwise continue the running sum
    assign base = a_item.first ? (use_pseudo ? pseudo_fold : 16'h0000) : sum_reg;

    // Drop the low byte of an odd tail
    assign word = a_item.odd_tail ? (a_item.data_word & ODD_TAIL_MASK) : a_item.data_word;

    assign word_total = {1'b0, base} + {1'b0, word};
    assign sum_next   = tce_fold({2'b0, word_total});

    // Result slot: load on a final word, clear when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (a_advance && a_item.last) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (a_advance) begin
                sum_reg <= sum_next;
            end
        end
    end

    // Hold the inverted sum for the result
    always_ff @(posedge aclk) begin
        if (a_advance && a_item.last) begin
            chk_reg <= ~sum_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_checksum = chk_reg;

endmodule
